>>> hdl/slot_pool_max_heap_queue_assert.svh
// assertion macros for the slot pool max heap queue
`ifndef SLOT_POOL_MAX_HEAP_QUEUE_ASSERT_SVH
`define SLOT_POOL_MAX_HEAP_QUEUE_ASSERT_SVH

// property that must hold in the same cycle as its trigger
`define SPMHQ_ASSERT_NOW(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
        else $error(msg);

// property that must hold in the cycle after its trigger
`define SPMHQ_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

>>> hdl/spmhq_pkg.sv
// shared constants and types for the slot pool max heap queue
package spmhq_pkg;

    // built capacity and payload width kept per slot
    localparam int CAPACITY      = 16;
    localparam int PAYLOAD_BYTES = 8;

    // fixed field widths
    localparam int CMD_W     = 2;
    localparam int PRI_W     = 7;
    localparam int PAYLOAD_W = 64;
    localparam int POS_W     = 5;
    localparam int STATUS_W  = 2;
    localparam int CNT_W     = 5;
    localparam int LIMIT_W   = 5;

    // internal widths derived from capacity and the field widths
    localparam int IDX_W  = $clog2(CAPACITY + 1);
    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int FLD_W  = (POS_W > LIMIT_W) ? POS_W : LIMIT_W;
    localparam int CMP_W  = (IDX_W > FLD_W) ? IDX_W : FLD_W;

    // bits of the payload kept in the slot store
    localparam logic [PAYLOAD_W-1:0] PAY_MASK =
        (PAYLOAD_BYTES >= 8) ? {PAYLOAD_W{1'b1}} :
        ((PAYLOAD_W'(1) << (8 * PAYLOAD_BYTES)) - PAYLOAD_W'(1));

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_BAD_POS = 2'd3
    } status_t;

    // one heap node
    typedef struct packed {
        logic [PRI_W-1:0]  pri;
        logic [SLOT_W-1:0] slot;
    } node_t;

    // result of the free slot search
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
    } free_slot_t;

endpackage

>>> hdl/slot_pool_max_heap_queue.sv
// top level of the slot pool max heap queue
// Max-priority queue of 64-bit payloads with 7-bit priorities, up to 16 items.
// One request is worked at a time; in_stall is high from the cycle after a
// request is taken until its result is loaded into the output register, and a
// new request may be taken while that result still waits on out_stall. Every
// heap level takes a registered read of the heap memory, then a compare and
// write back. Insert sifts the new node up; pop and remove take a node out,
// fill the hole with the last node and sift it down; clear and rejected
// requests go straight to the result. A result held by out_stall adds its
// wait to the request behind it. The slot limit register is taken only while
// the block is idle.
module slot_pool_max_heap_queue
    import spmhq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [PRI_W-1:0]     priority_req,
    input  logic [PAYLOAD_W-1:0] payload,
    input  logic [POS_W-1:0]     heap_position,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [STATUS_W-1:0]  status,
    output logic [PRI_W-1:0]     out_priority,
    output logic [PAYLOAD_W-1:0] out_payload,
    output logic                 is_full,
    output logic                 is_empty,
    output logic [CNT_W-1:0]     item_count,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [LIMIT_W-1:0]   cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_TAKE_RD,
        S_TAKE_LD,
        S_TAKE_PAY,
        S_DN_RD,
        S_DN_CMP,
        S_FINISH
    } state_t;

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      k_reg, k_next;
    logic [IDX_W-1:0]      n_reg, n_next;
    logic [IDX_W-1:0]      cnt_reg, cnt_next;
    node_t                 cur_reg, cur_next;
    logic [CAPACITY-1:0]   busy_reg, busy_next;
    logic [LIMIT_W-1:0]    lim_cfg_reg, lim_cfg_next;
    logic                  is_pop_reg, is_pop_next;
    status_t               res_status_reg, res_status_next;
    logic [PRI_W-1:0]      res_pri_reg, res_pri_next;
    logic [PAYLOAD_W-1:0]  res_pay_reg, res_pay_next;
    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [PRI_W-1:0]      out_priority_reg, out_priority_next;
    logic [PAYLOAD_W-1:0]  out_payload_reg, out_payload_next;
    logic                  is_full_reg, is_full_next;
    logic                  is_empty_reg, is_empty_next;
    logic [CNT_W-1:0]      item_count_reg, item_count_next;

    // heap memory, two read ports and one write port
    node_t                 heap_ram [0:CAPACITY];
    node_t                 heap_qa_reg;
    node_t                 heap_qb_reg;
    logic                  heap_we;
    logic [IDX_W-1:0]      heap_waddr;
    node_t                 heap_wdata;
    logic [IDX_W-1:0]      heap_ra;
    logic [IDX_W-1:0]      heap_rb;

    // slot store memory
    logic [PAYLOAD_W-1:0]  store_ram [0:CAPACITY-1];
    logic [PAYLOAD_W-1:0]  store_q_reg;
    logic                  store_we;
    logic [SLOT_W-1:0]     store_waddr;
    logic [PAYLOAD_W-1:0]  store_wdata;
    logic [SLOT_W-1:0]     store_ra;

    logic [IDX_W-1:0]      limit;
    logic [CMP_W-1:0]      lim_wide;
    free_slot_t            free;
    logic [IDX_W:0]        child_l;
    logic [IDX_W:0]        child_r;
    logic                  use_right;
    node_t                 child;
    logic                  accept;

    // effective slot limit, clamped to one through capacity
    always_comb
    begin
        lim_wide = CMP_W'(lim_cfg_reg);
        if (lim_wide == '0)
        begin
            lim_wide = CMP_W'(1);
        end
        else if (lim_wide > CMP_W'(CAPACITY))
        begin
            lim_wide = CMP_W'(CAPACITY);
        end
        limit = lim_wide[IDX_W-1:0];
    end

    spmhq_free_slot u_free_slot (
        .busy  (busy_reg),
        .limit (limit),
        .free  (free)
    );

    // children of the current node and the larger one
    assign child_l   = {k_reg, 1'b0};
    assign child_r   = {k_reg, 1'b1};
    assign use_right = (child_l < {1'b0, n_reg}) && (heap_qa_reg.pri < heap_qb_reg.pri);
    assign child     = use_right ? heap_qb_reg : heap_qa_reg;

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign accept    = in_valid && !in_stall;

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        k_next            = k_reg;
        n_next            = n_reg;
        cnt_next          = cnt_reg;
        cur_next          = cur_reg;
        busy_next         = busy_reg;
        lim_cfg_next      = lim_cfg_reg;
        is_pop_next       = is_pop_reg;
        res_status_next   = res_status_reg;
        res_pri_next      = res_pri_reg;
        res_pay_next      = res_pay_reg;
        out_valid_next    = out_valid_reg && out_stall;
        status_next       = status_reg;
        out_priority_next = out_priority_reg;
        out_payload_next  = out_payload_reg;
        is_full_next      = is_full_reg;
        is_empty_next     = is_empty_reg;
        item_count_next   = item_count_reg;

        heap_we     = 1'b0;
        heap_waddr  = k_reg;
        heap_wdata  = cur_reg;
        heap_ra     = k_reg;
        heap_rb     = cnt_reg;
        store_we    = 1'b0;
        store_waddr = free.slot;
        store_wdata = payload & PAY_MASK;
        store_ra    = heap_qa_reg.slot;

        if (cfg_valid && cfg_ready)
        begin
            lim_cfg_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = ST_DONE;
                    res_pri_next    = '0;
                    res_pay_next    = '0;
                    unique case (cmd_t'(cmd))
                        CMD_INSERT:
                        begin
                            if ((cnt_reg < limit) && free.found)
                            begin
                                store_we              = 1'b1;
                                busy_next[free.slot]  = 1'b1;
                                cnt_next              = cnt_reg + IDX_W'(1);
                                k_next                = cnt_reg + IDX_W'(1);
                                cur_next.pri          = priority_req;
                                cur_next.slot         = free.slot;
                                state_next            = S_UP_RD;
                            end
                            else
                            begin
                                res_status_next = ST_FULL;
                                state_next      = S_FINISH;
                            end
                        end
                        CMD_POP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                k_next      = IDX_W'(1);
                                is_pop_next = 1'b1;
                                state_next  = S_TAKE_RD;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if ((heap_position == '0) ||
                                (CMP_W'(heap_position) > CMP_W'(cnt_reg)))
                            begin
                                res_status_next = ST_BAD_POS;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                k_next      = heap_position[IDX_W-1:0];
                                is_pop_next = 1'b0;
                                state_next  = S_TAKE_RD;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            cnt_next   = '0;
                            busy_next  = '0;
                            state_next = S_FINISH;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            // sift up: fetch the parent
            S_UP_RD:
            begin
                if (k_reg > IDX_W'(1))
                begin
                    heap_ra    = k_reg >> 1;
                    state_next = S_UP_CMP;
                end
                else
                begin
                    heap_we    = 1'b1;
                    state_next = S_FINISH;
                end
            end

            // sift up: move the parent down or settle
            S_UP_CMP:
            begin
                heap_we = 1'b1;
                if (heap_qa_reg.pri < cur_reg.pri)
                begin
                    heap_wdata = heap_qa_reg;
                    k_next     = k_reg >> 1;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            // fetch the node taken out and the last node
            S_TAKE_RD:
            begin
                heap_ra    = k_reg;
                heap_rb    = cnt_reg;
                state_next = S_TAKE_LD;
            end

            // free the slot, start the payload read, shrink the heap
            S_TAKE_LD:
            begin
                if (int'(heap_qa_reg.slot) < CAPACITY)
                begin
                    busy_next[heap_qa_reg.slot] = 1'b0;
                end
                if (is_pop_reg)
                begin
                    res_pri_next = heap_qa_reg.pri;
                end
                store_ra   = heap_qa_reg.slot;
                cur_next   = heap_qb_reg;
                cnt_next   = cnt_reg - IDX_W'(1);
                n_next     = cnt_reg - IDX_W'(1);
                state_next = S_TAKE_PAY;
            end

            // capture the popped payload
            S_TAKE_PAY:
            begin
                if (is_pop_reg)
                begin
                    res_pay_next = store_q_reg;
                end
                state_next = S_DN_RD;
            end

            // sift down: fetch both children
            S_DN_RD:
            begin
                if ((n_reg >> 1) >= k_reg)
                begin
                    heap_ra    = child_l[IDX_W-1:0];
                    heap_rb    = child_r[IDX_W-1:0];
                    state_next = S_DN_CMP;
                end
                else
                begin
                    heap_we    = 1'b1;
                    state_next = S_FINISH;
                end
            end

            // sift down: move the larger child up or settle
            S_DN_CMP:
            begin
                heap_we = 1'b1;
                if (cur_reg.pri >= child.pri)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    heap_wdata = child;
                    k_next     = use_right ? child_r[IDX_W-1:0] : child_l[IDX_W-1:0];
                    state_next = S_DN_RD;
                end
            end

            // load the result once the output register is free
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    status_next       = res_status_reg;
                    out_priority_next = res_pri_reg;
                    out_payload_next  = res_pay_reg;
                    is_full_next      = (cnt_reg >= limit);
                    is_empty_next     = (cnt_reg == '0);
                    item_count_next   = CNT_W'(cnt_reg);
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            k_reg            <= '0;
            n_reg            <= '0;
            cnt_reg          <= '0;
            cur_reg          <= '0;
            busy_reg         <= '0;
            lim_cfg_reg      <= LIMIT_W'(CAPACITY);
            is_pop_reg       <= 1'b0;
            res_status_reg   <= ST_DONE;
            res_pri_reg      <= '0;
            res_pay_reg      <= '0;
            out_valid_reg    <= 1'b0;
            status_reg       <= '0;
            out_priority_reg <= '0;
            out_payload_reg  <= '0;
            is_full_reg      <= 1'b0;
            is_empty_reg     <= 1'b1;
            item_count_reg   <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            k_reg            <= k_next;
            n_reg            <= n_next;
            cnt_reg          <= cnt_next;
            cur_reg          <= cur_next;
            busy_reg         <= busy_next;
            lim_cfg_reg      <= lim_cfg_next;
            is_pop_reg       <= is_pop_next;
            res_status_reg   <= res_status_next;
            res_pri_reg      <= res_pri_next;
            res_pay_reg      <= res_pay_next;
            out_valid_reg    <= out_valid_next;
            status_reg       <= status_next;
            out_priority_reg <= out_priority_next;
            out_payload_reg  <= out_payload_next;
            is_full_reg      <= is_full_next;
            is_empty_reg     <= is_empty_next;
            item_count_reg   <= item_count_next;
        end
    end

    // heap memory
    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            heap_ram[heap_waddr] <= heap_wdata;
        end
        heap_qa_reg <= heap_ram[heap_ra];
        heap_qb_reg <= heap_ram[heap_rb];
    end

    // slot store memory
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_ram[store_waddr] <= store_wdata;
        end
        store_q_reg <= store_ram[store_ra];
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_priority = out_priority_reg;
    assign out_payload  = out_payload_reg;
    assign is_full      = is_full_reg;
    assign is_empty     = is_empty_reg;
    assign item_count   = item_count_reg;

    `include "slot_pool_max_heap_queue_assert.svh"

    // busy slots match the queued count between requests
    `SPMHQ_ASSERT_NOW(a_busy_matches_count, state_reg == S_IDLE,
        $countones(busy_reg) == int'(cnt_reg), "busy slots differ from item count")

    // a taken request keeps the block busy in the next cycle
    `SPMHQ_ASSERT_NEXT(a_request_holds_block, accept, in_stall,
        "block idle right after a request")

    // a new result only comes from the finish step
    `SPMHQ_ASSERT_NOW(a_result_from_finish, $rose(out_valid_reg),
        $past(state_reg) == S_FINISH, "result loaded outside finish")

endmodule

>>> hdl/spmhq_free_slot.sv
// lowest free slot below the slot limit
module spmhq_free_slot
    import spmhq_pkg::*;
(
    input  logic [CAPACITY-1:0] busy,
    input  logic [IDX_W-1:0]    limit,
    output free_slot_t          free
);

    logic [CAPACITY-1:0] avail;
    logic [CAPACITY-1:0] lowest;

    // slots that are free and enabled
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            avail[i] = !busy[i] && (i < int'(limit));
        end
    end

    // isolate the lowest set bit
    assign lowest = avail & (~avail + CAPACITY'(1));

    // encode the one-hot pick
    always_comb
    begin
        free.found = |avail;
        free.slot  = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (lowest[i])
            begin
                free.slot = free.slot | SLOT_W'(i);
            end
        end
    end

endmodule

>>> bench/slot_pool_max_heap_queue_tb.sv
// self-checking testbench for the slot pool max heap queue
module slot_pool_max_heap_queue_tb;
    import spmhq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 16;
    localparam int PRINT_CAP   = 40;

    typedef struct {
        cmd_t                 op;
        logic [PRI_W-1:0]     pri;
        logic [PAYLOAD_W-1:0] word;
        logic [POS_W-1:0]     pos;
    } request_t;

    typedef struct packed {
        status_t              status;
        logic [PRI_W-1:0]     pri;
        logic [PAYLOAD_W-1:0] word;
        logic                 full;
        logic                 empty;
        logic [CNT_W-1:0]     count;
    } heap_reply_t;

    // block ports
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [CMD_W-1:0]     cmd = '0;
    logic [PRI_W-1:0]     priority_req = '0;
    logic [PAYLOAD_W-1:0] payload = '0;
    logic [POS_W-1:0]     heap_position = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [PRI_W-1:0]     out_priority;
    logic [PAYLOAD_W-1:0] out_payload;
    logic                 is_full;
    logic                 is_empty;
    logic [CNT_W-1:0]     item_count;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [LIMIT_W-1:0]   cfg_data = '0;

    // predicted heap contents and slot pool
    logic [PRI_W-1:0]     heap_pri   [0:CAPACITY] = '{default: '0};
    logic [SLOT_W-1:0]    heap_slot  [0:CAPACITY] = '{default: '0};
    logic                 slot_taken [0:CAPACITY-1] = '{default: 1'b0};
    logic [PAYLOAD_W-1:0] slot_word  [0:CAPACITY-1] = '{default: '0};
    int                   queued = 0;
    logic [LIMIT_W-1:0]   limit_reg = LIMIT_W'(CAPACITY);

    request_t    request_backlog[$];
    heap_reply_t predicted_replies[$];

    int accepted_total = 0;
    int replies_seen = 0;
    int mismatches = 0;
    int gap_left = 0;
    int stall_left = 0;
    int plan_count = 0;
    bit filling = 1'b1;

    slot_pool_max_heap_queue dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .priority_req  (priority_req),
        .payload       (payload),
        .heap_position (heap_position),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .out_priority  (out_priority),
        .out_payload   (out_payload),
        .is_full       (is_full),
        .is_empty      (is_empty),
        .item_count    (item_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // clock and reset
    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // register value 0 behaves as 1, anything above capacity as capacity
    function automatic int eff_limit();
        int v = limit_reg;
        if (v < 1) v = 1;
        if (v > CAPACITY) v = CAPACITY;
        return v;
    endfunction

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // stretches with no idling on either side
    function automatic bit calm();
        return (accepted_total % 160) < 40;
    endfunction

    // move a node toward the root while its parent is smaller
    task automatic float_up(int k);
        logic [PRI_W-1:0]  p;
        logic [SLOT_W-1:0] s;
        p = heap_pri[k];
        s = heap_slot[k];
        while (k > 1 && heap_pri[k >> 1] < p)
        begin
            heap_pri[k]  = heap_pri[k >> 1];
            heap_slot[k] = heap_slot[k >> 1];
            k = k >> 1;
        end
        heap_pri[k]  = p;
        heap_slot[k] = s;
    endtask

    // move a node toward the leaves while a child is larger
    task automatic sink_down(int n, int k);
        logic [PRI_W-1:0]  p;
        logic [SLOT_W-1:0] s;
        int                c;
        p = heap_pri[k];
        s = heap_slot[k];
        while ((n >> 1) >= k)
        begin
            c = k + k;
            if (c < n && heap_pri[c] < heap_pri[c + 1]) c++;
            if (p >= heap_pri[c]) break;
            heap_pri[k]  = heap_pri[c];
            heap_slot[k] = heap_slot[c];
            k = c;
        end
        heap_pri[k]  = p;
        heap_slot[k] = s;
    endtask

    // free the node's slot, fill the hole with the last node, sift down only
    task automatic drop_node(int at);
        slot_taken[heap_slot[at]] = 1'b0;
        heap_pri[at]  = heap_pri[queued];
        heap_slot[at] = heap_slot[queued];
        queued--;
        sink_down(queued, at);
    endtask

    // apply one request to the predicted queue and record its reply
    task automatic predict_heap_op(cmd_t op, logic [PRI_W-1:0] pri,
                                   logic [PAYLOAD_W-1:0] word, logic [POS_W-1:0] pos);
        int          lim;
        int          free_slot;
        int          i;
        heap_reply_t r;
        lim = eff_limit();
        r = '0;
        r.status = ST_DONE;
        case (op)
            CMD_INSERT:
            begin
                free_slot = lim;
                if (queued < lim)
                begin
                    for (i = 0; i < lim; i++)
                    begin
                        if (!slot_taken[i])
                        begin
                            free_slot = i;
                            break;
                        end
                    end
                end
                if (free_slot >= lim)
                    r.status = ST_FULL;
                else
                begin
                    slot_word[free_slot]  = word & PAY_MASK;
                    slot_taken[free_slot] = 1'b1;
                    queued++;
                    heap_slot[queued] = SLOT_W'(free_slot);
                    heap_pri[queued]  = pri;
                    float_up(queued);
                end
            end
            CMD_POP:
            begin
                if (queued == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.pri  = heap_pri[1];
                    r.word = slot_word[heap_slot[1]];
                    drop_node(1);
                end
            end
            CMD_REMOVE:
            begin
                if (pos < 1 || int'(pos) > queued)
                    r.status = ST_BAD_POS;
                else
                    drop_node(int'(pos));
            end
            default:
            begin
                queued = 0;
                slot_taken = '{default: 1'b0};
            end
        endcase
        r.full  = (queued >= lim);
        r.empty = (queued == 0);
        r.count = CNT_W'(queued);
        predicted_replies.push_back(r);
    endtask

    task automatic flag_mismatch(string what, logic [PAYLOAD_W-1:0] got,
                                 logic [PAYLOAD_W-1:0] want);
        if (mismatches < PRINT_CAP)
            $display("reply %0d %s: got %0h, want %0h", replies_seen, what, got, want);
        mismatches++;
    endtask

    task automatic queue_request(cmd_t op, int pri, logic [PAYLOAD_W-1:0] word, int pos);
        request_t q;
        q.op   = op;
        q.pri  = PRI_W'(pri);
        q.word = word;
        q.pos  = POS_W'(pos);
        request_backlog.push_back(q);
    endtask

    // random requests: mostly fill and drain tides with valid positions, some noise
    task automatic plan_random(int n);
        int       lim;
        int       r;
        request_t q;
        lim = eff_limit();
        repeat (n)
        begin
            if (plan_count >= lim) filling = 1'b0;
            else if (plan_count == 0) filling = 1'b1;
            else if ($urandom_range(0, 99) < 3) filling = !filling;
            r = $urandom_range(0, 99);
            if (r < 20) q.pri = PRI_W'($urandom_range(0, 3));
            else if (r < 25) q.pri = '1;
            else q.pri = PRI_W'($urandom_range(0, 127));
            q.word = {$urandom(), $urandom()};
            q.pos  = POS_W'($urandom_range(0, 31));
            r = $urandom_range(0, 99);
            if (r < 2) q.op = CMD_CLEAR;
            else if (r < (filling ? 70 : 30)) q.op = CMD_INSERT;
            else if (r < (filling ? 85 : 65)) q.op = CMD_POP;
            else q.op = CMD_REMOVE;
            // track the count so that most removes name a live position
            case (q.op)
                CMD_INSERT:
                begin
                    if (plan_count < lim) plan_count++;
                end
                CMD_POP:
                begin
                    if (plan_count > 0) plan_count--;
                end
                CMD_REMOVE:
                begin
                    if (plan_count > 0 && $urandom_range(0, 9) != 0)
                        q.pos = POS_W'($urandom_range(1, plan_count));
                    if (q.pos >= 1 && int'(q.pos) <= plan_count) plan_count--;
                end
                default:
                begin
                    plan_count = 0;
                end
            endcase
            request_backlog.push_back(q);
        end
    endtask

    // wait until every request is taken and every reply has come, then settle
    task automatic wait_idle();
        while (request_backlog.size() != 0 || in_valid || predicted_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_limit(logic [LIMIT_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_reg = value;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : driver
        request_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_heap_op(cmd_t'(cmd), priority_req, payload, heap_position);
                accepted_total++;
                if (!calm()) gap_left = pick_gap();
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (request_backlog.size() != 0)
                begin
                    nxt = request_backlog.pop_front();
                    cmd           <= nxt.op;
                    priority_req  <= nxt.pri;
                    payload       <= nxt.word;
                    heap_position <= nxt.pos;
                    in_valid      <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // reply monitor and output stall
    always @(posedge clk or negedge rst_n)
    begin : monitor
        heap_reply_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_replies.size() == 0)
                    flag_mismatch("reply with none awaited, status", 64'(status), '0);
                else
                begin
                    want = predicted_replies.pop_front();
                    if (status !== want.status)
                        flag_mismatch("status", 64'(status), 64'(want.status));
                    if (out_priority !== want.pri)
                        flag_mismatch("out_priority", 64'(out_priority), 64'(want.pri));
                    if (out_payload !== want.word)
                        flag_mismatch("out_payload", out_payload, want.word);
                    if (is_full !== want.full)
                        flag_mismatch("is_full", 64'(is_full), 64'(want.full));
                    if (is_empty !== want.empty)
                        flag_mismatch("is_empty", 64'(is_empty), 64'(want.empty));
                    if (item_count !== want.count)
                        flag_mismatch("item_count", 64'(item_count), 64'(want.count));
                end
                replies_seen++;
            end
            if (stall_left == 0 && !calm()) stall_left = pick_gap();
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // run limit
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // stimulus sequence
    initial
    begin : stimulus
        logic [LIMIT_W-1:0] phase_limits [0:8];
        int                 i;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // rejections on an empty queue
        queue_request(CMD_POP, 0, '0, 1);
        queue_request(CMD_REMOVE, 0, '0, 1);
        // build a heap, extreme payloads
        queue_request(CMD_INSERT, 100, 64'h0, 0);
        queue_request(CMD_INSERT, 50, '1, 0);
        queue_request(CMD_INSERT, 90, 64'h5555_5555_5555_5555, 0);
        queue_request(CMD_INSERT, 40, 64'hAAAA_AAAA_AAAA_AAAA, 0);
        queue_request(CMD_INSERT, 45, 64'h8000_0000_0000_0001, 0);
        queue_request(CMD_INSERT, 88, 64'h0123_4567_89AB_CDEF, 0);
        // bad positions: zero, far above, just above the count
        queue_request(CMD_REMOVE, 0, '0, 0);
        queue_request(CMD_REMOVE, 0, '0, 31);
        queue_request(CMD_REMOVE, 0, '0, 7);
        // moved node larger than its new parent stays put
        queue_request(CMD_REMOVE, 0, '0, 4);
        // top and bottom priorities, ties at the root
        queue_request(CMD_INSERT, 127, 64'hFEDC_BA98_7654_3210, 0);
        queue_request(CMD_INSERT, 0, 64'h1, 0);
        queue_request(CMD_INSERT, 127, 64'h7FFF_FFFF_FFFF_FFFF, 0);
        queue_request(CMD_POP, 0, '0, 0);
        queue_request(CMD_POP, 0, '0, 0);
        // remove the last node
        queue_request(CMD_REMOVE, 0, '0, 6);
        // clear a loaded queue, then an empty one
        queue_request(CMD_CLEAR, 0, '0, 0);
        queue_request(CMD_CLEAR, 0, '0, 0);
        queue_request(CMD_POP, 0, '0, 0);
        wait_idle();

        // limit settings, including out-of-range values and a drop below the count
        phase_limits = '{5'd16, 5'd3, 5'd1, 5'd0, 5'd31, 5'd2, 5'd8, 5'd16, 5'd31};
        phase_limits[7] = LIMIT_W'($urandom_range(1, CAPACITY));
        for (i = 0; i < 9; i++)
        begin
            write_limit(phase_limits[i]);
            plan_count = queued;
            if (i == 4)
            begin
                // sender holds off until every reply is back
                plan_random(60);
                wait_idle();
                plan_random(60);
            end
            else
                plan_random(120);
            // leave more items queued than the next, lower limit allows
            if (i == 0)
                repeat (6) queue_request(CMD_INSERT, $urandom_range(0, 127),
                                         {$urandom(), $urandom()}, 0);
            wait_idle();
        end

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> slot_pool_max_heap_queue.f
+incdir+hdl
hdl/spmhq_pkg.sv
hdl/spmhq_free_slot.sv
hdl/slot_pool_max_heap_queue.sv
bench/slot_pool_max_heap_queue_tb.sv
